[hw/rtl/pip_pkg.sv]
// shared constants and token type for the point-in-polygon tester
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_WIDTH  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    logic             valid;
    coord_t           px;
    coord_t           py;
    coord_t           xprev;
    coord_t           yprev;
    logic [CNT_W-1:0] left;
    logic             parity;
    logic             pend;
    prod_t            lhs;
    prod_t            rhs;
  } token_t;

endpackage

[hw/rtl/point_in_polygon_test.sv]
// top level of the even-odd point-in-polygon tester
//
// A vertex write is taken and gives no result. A query runs through a
// chain of 16 vertex cells, one cell per cycle, each cell testing the edge
// that ends at its vertex; done is high for one cycle, and busy drops in
// the cycle that done is high, so the next query can be accepted then. A
// query passes through the whole chain, whatever the vertex count. The
// result cannot be held off: it is valid only in the cycle that done is
// high. The vertex count register can be written whenever busy is low.
module point_in_polygon_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation,
  input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vertex_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] vertex_y,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]          cfg_data,
  output logic                               done,
  output logic                               inside_res
);
  import pip_pkg::*;

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic             final_cross;
  token_t           tok [0:MAX_VERTICES];
  token_t           tok_head;
  token_t           tok0_next;
  coord_t           cell_x [0:MAX_VERTICES-1];
  coord_t           cell_y [0:MAX_VERTICES-1];

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign count_m1  = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count <= (cfg_data > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : cfg_data;
    end
  end

  // the first cell's edge starts at the last vertex in use
  always_comb begin
    tok0_next        = '0;
    tok0_next.valid  = accept && (operation == OP_QUERY);
    tok0_next.px     = point_x;
    tok0_next.py     = point_y;
    tok0_next.xprev  = cell_x[count_m1[IDX_W-1:0]];
    tok0_next.yprev  = cell_y[count_m1[IDX_W-1:0]];
    tok0_next.left   = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head <= '0;
    end else begin
      tok_head <= tok0_next;
    end
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic we;

    assign we = accept && (operation == OP_WRITE) && (vertex_index == IDX_W'(g)) &&
                ({1'b0, vertex_index} < count);

    pip_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .we   (we),
      .wx   (vertex_x),
      .wy   (vertex_y),
      .tin  (tok[g]),
      .tout (tok[g+1]),
      .vx   (cell_x[g]),
      .vy   (cell_y[g])
    );
  end

  assign final_cross = tok[MAX_VERTICES].pend &&
                       ($signed(tok[MAX_VERTICES].lhs) < $signed(tok[MAX_VERTICES].rhs));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tok[MAX_VERTICES].valid;
      if (accept && (operation == OP_QUERY)) begin
        busy <= 1'b1;
      end else if (tok[MAX_VERTICES].valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    inside_res <= tok[MAX_VERTICES].parity ^ final_cross;
  end

endmodule

[hw/rtl/pip_cell.sv]
// one vertex cell: holds a vertex, tests the edge from the previous vertex
module pip_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  pip_pkg::coord_t wx,
  input  pip_pkg::coord_t wy,
  input  pip_pkg::token_t tin,
  output pip_pkg::token_t tout,
  output pip_pkg::coord_t vx,
  output pip_pkg::coord_t vy
);
  import pip_pkg::*;

  coord_t                    xi;
  coord_t                    yi;
  logic                      active;
  logic                      straddle;
  logic                      crossed;
  logic signed [DIFF_W-1:0]  a;
  logic signed [DIFF_W-1:0]  b;
  logic signed [DIFF_W-1:0]  c;
  logic signed [DIFF_W-1:0]  dy;
  prod_t                     p1;
  prod_t                     p2;
  token_t                    tout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xi <= '0;
      yi <= '0;
    end else if (we) begin
      xi <= wx;
      yi <= wy;
    end
  end

  assign vx = xi;
  assign vy = yi;

  assign active   = tin.valid && (tin.left != '0);
  assign straddle = ($signed(yi) < $signed(tin.py) && $signed(tin.yprev) >= $signed(tin.py)) ||
                    ($signed(tin.yprev) < $signed(tin.py) && $signed(yi) >= $signed(tin.py));

  assign a  = DIFF_W'($signed(tin.py))    - DIFF_W'($signed(yi));
  assign b  = DIFF_W'($signed(tin.xprev)) - DIFF_W'($signed(xi));
  assign c  = DIFF_W'($signed(tin.px))    - DIFF_W'($signed(xi));
  assign dy = DIFF_W'($signed(tin.yprev)) - DIFF_W'($signed(yi));
  assign p1 = a * b;
  assign p2 = c * dy;

  // finish the edge handed over by the previous cell
  assign crossed = tin.pend && ($signed(tin.lhs) < $signed(tin.rhs));

  always_comb begin
    tout_next        = tin;
    tout_next.parity = tin.parity ^ crossed;
    tout_next.xprev  = xi;
    tout_next.yprev  = yi;
    tout_next.left   = active ? tin.left - CNT_W'(1) : tin.left;
    tout_next.pend   = active && straddle;
    if (dy > 0) begin
      tout_next.lhs = p1;
      tout_next.rhs = p2;
    end else begin
      tout_next.lhs = p2;
      tout_next.rhs = p1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tout_next;
    end
  end

endmodule

[tb/sv/pip_inside_checker.sv]
// checker for the point-in-polygon tester: predicts each inside flag and compares
`timescale 1ns / 100ps

module pip_inside_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          operation,
  input  logic [pip_pkg::IDX_W-1:0]     vertex_index,
  input  pip_pkg::coord_t               vertex_x,
  input  pip_pkg::coord_t               vertex_y,
  input  pip_pkg::coord_t               point_x,
  input  pip_pkg::coord_t               point_y,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          done,
  input  logic                          inside_res,
  output int                            errors,
  output int                            pending,
  output int                            inside_total
);
  import pip_pkg::*;

  coord_t           poly_x [MAX_VERTICES];
  coord_t           poly_y [MAX_VERTICES];
  logic [CNT_W-1:0] poly_count;
  bit               inside_due [$];
  bit               want;
  int unsigned      in_use;

  function automatic bit ray_parity(input coord_t qx, input coord_t qy);
    int unsigned n;
    int unsigned prev;
    longint      lx, ly, xa, ya, xb, yb, dy;
    bit          lt;
    bit          odd;
    n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : poly_count;
    lx   = qx;
    ly   = qy;
    odd  = 1'b0;
    prev = (n == 0) ? 0 : n - 1;
    for (int unsigned k = 0; k < n; k++) begin
      xa = poly_x[k];
      ya = poly_y[k];
      xb = poly_x[prev];
      yb = poly_y[prev];
      if ((ya < ly && yb >= ly) || (yb < ly && ya >= ly)) begin
        dy = yb - ya;
        // crossing left of the point, compared without division
        if (dy > 0)
          lt = (ly - ya) * (xb - xa) < (lx - xa) * dy;
        else
          lt = (lx - xa) * dy < (ly - ya) * (xb - xa);
        if (lt)
          odd = !odd;
      end
      prev = k;
    end
    return odd;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        poly_x[k] = '0;
        poly_y[k] = '0;
      end
      poly_count = '0;
      inside_due.delete();
      errors       = 0;
      pending      = 0;
      inside_total = 0;
    end else begin
      if (done) begin
        if (inside_due.size() == 0) begin
          errors++;
          $error("inside_res: result with no query outstanding, actual %0b", inside_res);
        end else begin
          want = inside_due.pop_front();
          if (inside_res !== want) begin
            errors++;
            $error("inside_res mismatch: expected %0b actual %0b", want, inside_res);
          end
        end
        if (inside_res === 1'b1)
          inside_total++;
      end
      if (start && !busy) begin
        if (operation == OP_QUERY) begin
          inside_due.push_back(ray_parity(point_x, point_y));
        end else begin
          in_use = (poly_count > MAX_VERTICES) ? MAX_VERTICES : poly_count;
          if (vertex_index < in_use) begin
            poly_x[vertex_index] = vertex_x;
            poly_y[vertex_index] = vertex_y;
          end
        end
      end
      // a transaction in the same cycle still sees the old count
      if (cfg_valid && cfg_ready)
        poly_count = cfg_data;
      pending = inside_due.size();
    end
  end

endmodule

[tb/sv/tb_point_in_polygon_test.sv]
// testbench top for the point-in-polygon tester: stimulus and verdict
`timescale 1ns / 100ps

module tb_point_in_polygon_test;
  import pip_pkg::*;

  typedef enum int {SPREAD_NEAR, SPREAD_FULL, SPREAD_EXTREME} spread_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic             operation;
  logic [IDX_W-1:0] vertex_index;
  coord_t           vertex_x;
  coord_t           vertex_y;
  coord_t           point_x;
  coord_t           point_y;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  logic             done;
  logic             inside_res;

  int errors;
  int pending;
  int inside_total;
  int n_writes;
  int n_queries;
  int n_settings;
  bit quiet;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_in_polygon_test uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .vertex_index (vertex_index),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .point_x      (point_x),
    .point_y      (point_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .inside_res   (inside_res)
  );

  pip_inside_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .vertex_index (vertex_index),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .point_x      (point_x),
    .point_y      (point_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .inside_res   (inside_res),
    .errors       (errors),
    .pending      (pending),
    .inside_total (inside_total)
  );

  function automatic coord_t pick_coord(input spread_t s);
    case (s)
      SPREAD_NEAR: return coord_t'(int'($urandom_range(0, 400)) - 200);
      SPREAD_FULL: return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return coord_t'(-32768);
          1:       return coord_t'(32767);
          2:       return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  // one transaction; returns at a falling edge, with start still high unless a random gap dropped it
  task automatic send(input logic op, input int idx, input coord_t vx, input coord_t vy,
                      input coord_t px, input coord_t py);
    operation    = op;
    vertex_index = idx[IDX_W-1:0];
    vertex_x     = vx;
    vertex_y     = vy;
    point_x      = px;
    point_y      = py;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_QUERY)
      n_queries++;
    else
      n_writes++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start        = 1'b0;
      operation    = 1'($urandom);
      vertex_index = IDX_W'($urandom);
      point_x      = coord_t'($urandom);
      point_y      = coord_t'($urandom);
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  task automatic drain(input int extra);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_count(input int cnt);
    drain(24);
    cfg_valid = 1'b1;
    cfg_data  = CNT_W'(cnt);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = CNT_W'($urandom);
    n_settings++;
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int      cnt;
    int      slots;
    int      r;
    spread_t spread;
    spread_t pspread;

    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_WRITE;
    vertex_index = '0;
    vertex_x     = '0;
    vertex_y     = '0;
    point_x      = '0;
    point_y      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    n_writes     = 0;
    n_queries    = 0;
    n_settings   = 0;
    quiet        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // square around the origin, points inside, outside and on edges
    set_count(4);
    send(OP_WRITE, 0, -100, -100, 0, 0);
    send(OP_WRITE, 1, 100, -100, 0, 0);
    send(OP_WRITE, 2, 100, 100, 0, 0);
    send(OP_WRITE, 3, -100, 100, 0, 0);
    send(OP_QUERY, 0, 0, 0, 0, 0);
    send(OP_QUERY, 0, 0, 0, 250, 0);
    send(OP_QUERY, 0, 0, 0, 0, 100);
    send(OP_QUERY, 0, 0, 0, 100, 0);
    send(OP_QUERY, 0, 0, 0, -100, 50);
    send(OP_QUERY, 0, 0, 0, 0, -100);
    // writes beyond the count are dropped
    send(OP_WRITE, 4, 32767, 32767, 0, 0);
    send(OP_WRITE, 15, -32768, -32768, 0, 0);
    // full table with extreme vertices
    set_count(16);
    send(OP_WRITE, 15, 32767, -32768, 0, 0);
    send(OP_WRITE, 0, -32768, 32767, 0, 0);
    send(OP_QUERY, 0, 0, 0, 32767, 32767);
    send(OP_QUERY, 0, 0, 0, -32768, -32768);
    send(OP_QUERY, 0, 0, 0, 0, 0);
    // empty polygon
    set_count(0);
    send(OP_QUERY, 0, 0, 0, 0, 0);
    send(OP_WRITE, 0, 5, 5, 0, 0);
    // count above the table size saturates
    set_count(31);
    send(OP_QUERY, 0, 0, 0, 1, 1);
    // triangle with a horizontal base
    set_count(3);
    send(OP_WRITE, 0, 0, 0, 0, 0);
    send(OP_WRITE, 1, 100, 0, 0, 0);
    send(OP_WRITE, 2, 50, 80, 0, 0);
    send(OP_QUERY, 0, 0, 0, 50, 0);
    send(OP_QUERY, 0, 0, 0, 50, 40);

    for (int ph = 0; ph < 24; ph++) begin
      quiet = (ph >= 8 && ph < 12);
      r = $urandom_range(0, 99);
      if (r < 70)
        cnt = $urandom_range(3, 16);
      else if (r < 80)
        cnt = $urandom_range(0, 2);
      else if (r < 90)
        cnt = 16;
      else
        cnt = $urandom_range(17, 31);
      set_count(cnt);
      slots = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
      r = $urandom_range(0, 99);
      spread = (r < 70) ? SPREAD_NEAR : (r < 90) ? SPREAD_FULL : SPREAD_EXTREME;
      for (int k = 0; k < slots; k++)
        send(OP_WRITE, k, pick_coord(spread), pick_coord(spread),
             coord_t'($urandom), coord_t'($urandom));
      for (int q = 0; q < 34; q++) begin
        r = $urandom_range(0, 99);
        pspread = ($urandom_range(0, 9) < 8) ? spread : spread_t'($urandom_range(0, 2));
        if (r < 85)
          send(OP_QUERY, $urandom_range(0, 15), coord_t'($urandom), coord_t'($urandom),
               pick_coord(pspread), pick_coord(pspread));
        else if (r < 95)
          send(OP_WRITE, $urandom_range(0, 15), pick_coord(spread), pick_coord(spread),
               coord_t'($urandom), coord_t'($urandom));
        else
          send(OP_QUERY, 0, 0, 0, pick_coord(SPREAD_EXTREME), pick_coord(pspread));
        if ($urandom_range(0, 99) == 0)
          drain(0);
      end
    end

    drain(30);
    $display("run covered %0d vertex writes and %0d queries, %0d of them inside",
             n_writes, n_queries, inside_total);
    $display("vertex count set %0d times, zero and saturating counts included", n_settings);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
